### hw/rtl/lru_ct_pkg.sv
// Shared constants for the LRU connection table: action codes, register
// indexes, protocol numbers and connection states. No dependencies.
`default_nettype none

package lru_ct_pkg;

    localparam int KEY_W = 104;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_TOUCH  = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_SWEEP  = 2'd3;

    localparam logic [2:0] REG_CAPACITY  = 3'd0;
    localparam logic [2:0] REG_TCP_HS    = 3'd1;
    localparam logic [2:0] REG_TCP_EST   = 3'd2;
    localparam logic [2:0] REG_TCP_CLOSE = 3'd3;
    localparam logic [2:0] REG_UDP       = 3'd4;
    localparam logic [2:0] REG_ICMP      = 3'd5;

    localparam logic [7:0] IPP_ICMP = 8'd1;
    localparam logic [7:0] IPP_TCP  = 8'd6;
    localparam logic [7:0] IPP_UDP  = 8'd17;

    localparam logic [2:0] CS_CLOSED      = 3'd0;
    localparam logic [2:0] CS_ESTABLISHED = 3'd3;
    localparam logic [2:0] CS_FIN_WAIT    = 3'd4;
    localparam logic [2:0] CS_CLOSE_WAIT  = 3'd5;

    typedef logic [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

### hw/rtl/lru_connection_table.sv
// Top level of the LRU connection table: entry memories, recency ranks and
// the sequencer that walks them. Depends on lru_ct_pkg.
`default_nettype none

// The table holds up to TABLE_SLOTS five-tuple entries in synchronous
// memories with one read and one write port (one read and one write per
// cycle, registered read). Every action is handled by walking the slots one
// per cycle, so the cost is set by that walk. Lookup-or-insert and remove
// make one walk to match the key, find the least recent entry and the
// lowest free slot, then one walk that rewrites the recency ranks. Touch
// reads the rank, then makes the rank walk. Sweep makes an expiry walk, a
// walk that builds a table of how many removed ranks lie below each rank,
// and a walk that closes the gaps in the surviving ranks. One transfer is
// taken at a time; a finished result waits in the output register while the
// next transfer is accepted. Configuration is written only while idle: the
// user must keep to this, since the block itself does not enforce it.

module lru_connection_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic [31:0] now,
    input  logic [5:0]  slot_index,
    input  logic [2:0]  new_conn_state,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [5:0]  slot,
    output logic        error,
    output logic        evicted,
    output logic [6:0]  removed_count,
    output logic [6:0]  occupancy,
    output logic [31:0] entry_first_seen,
    output logic [2:0]  entry_state
);
    import lru_ct_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_TREAD  = 4'd3;
    localparam logic [3:0] S_TWAIT  = 4'd4;
    localparam logic [3:0] S_RANK   = 4'd5;
    localparam logic [3:0] S_SWEEP  = 4'd6;
    localparam logic [3:0] S_SHIFT  = 4'd7;
    localparam logic [3:0] S_COMP   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [1:0] M_PROMOTE = 2'd0;
    localparam logic [1:0] M_INSERT  = 2'd1;
    localparam logic [1:0] M_DROP    = 2'd2;

    // Configuration registers.
    logic [6:0]  cap_reg;
    logic [15:0] to_hs_reg, to_est_reg, to_close_reg, to_udp_reg, to_icmp_reg;

    // Entry memories.
    key_t          key_mem   [TABLE_SLOTS];
    logic [31:0]   last_mem  [TABLE_SLOTS];
    logic [31:0]   first_mem [TABLE_SLOTS];
    logic [2:0]    cst_mem   [TABLE_SLOTS];
    logic [IW-1:0] rank_mem  [TABLE_SLOTS];
    logic [IW-1:0] shift_mem [TABLE_SLOTS];

    key_t          key_q;
    logic [31:0]   last_q, first_q;
    logic [2:0]    cst_q;
    logic [IW-1:0] rank_q, shift_q;

    logic [3:0]    state_reg;
    logic [1:0]    act_reg;
    key_t          key_reg;
    logic [31:0]   now_reg;
    logic [5:0]    sidx_reg;
    logic [2:0]    nst_reg;

    logic [IW-1:0] idx_reg, p_idx_reg, p2_idx_reg, p2_rank_reg;
    logic          iss_reg, p_vld_reg, p2_vld_reg;

    logic          fnd_reg, vic_vld_reg, free_vld_reg;
    logic [IW-1:0] f_slot_reg, f_rank_reg, vic_reg, best_reg, free_reg;
    logic [31:0]   f_first_reg;
    logic [2:0]    f_st_reg;

    logic [1:0]    mode_reg;
    logic [IW-1:0] ms_reg, mr_reg;
    logic          mev_reg;

    logic [TABLE_SLOTS-1:0] valid_reg, drop_mask_reg;
    logic [CW-1:0] count_reg, rem_reg;
    logic [IW-1:0] run_reg;

    logic          r_hit_reg, r_err_reg, r_ev_reg;
    logic [5:0]    r_slot_reg;
    logic [31:0]   r_first_reg;
    logic [2:0]    r_st_reg;

    logic          out_valid_reg;
    logic          ov_hit_reg, ov_err_reg, ov_ev_reg;
    logic [5:0]    ov_slot_reg;
    logic [6:0]    ov_rem_reg, ov_occ_reg;
    logic [31:0]   ov_first_reg;
    logic [2:0]    ov_st_reg;

    // Combinational helpers.
    logic          accept, pass_done, p_valid_slot;
    logic [IW-1:0] rd_addr, sidx_w;
    logic [IW+5:0] sidx_ext;
    logic          sidx_ok;
    logic [15:0]   lim16;
    logic          evict_c, ins_c;
    logic [IW-1:0] ns_c;
    logic [15:0]   timeout_c;
    logic [31:0]   idle_c;
    logic          expire_c;
    logic          rk_we;
    logic [IW-1:0] rk_addr, rk_data;
    logic          ent_we, last_we, cst_we;
    logic [IW-1:0] last_addr, cst_addr;
    logic [2:0]    cst_data;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign pass_done = !iss_reg && !p_vld_reg && !p2_vld_reg;
    assign p_valid_slot = valid_reg[p_idx_reg];

    assign sidx_ext = (IW + 6)'(sidx_reg);
    assign sidx_ok  = sidx_ext < (IW + 6)'(TABLE_SLOTS);
    assign sidx_w   = sidx_ext[IW-1:0];
    assign rd_addr  = (state_reg == S_TREAD) ? sidx_w : idx_reg;

    // Effective limit: zero acts as one, anything above the table size as full.
    always_comb
    begin
        if (cap_reg == 7'd0)
            lim16 = 16'd1;
        else if (16'(cap_reg) > 16'(TABLE_SLOTS))
            lim16 = 16'(TABLE_SLOTS);
        else
            lim16 = 16'(cap_reg);
    end

    // Insert decisions after the match walk. When an entry is evicted the new
    // one goes to the lower of the victim slot and the first free slot.
    assign evict_c = (16'(count_reg) >= lim16) && vic_vld_reg;
    assign ins_c   = evict_c || free_vld_reg;
    always_comb
    begin
        if (evict_c && !(free_vld_reg && free_reg < vic_reg))
            ns_c = vic_reg;
        else
            ns_c = free_reg;
    end

    // Idle timeout of the slot in the first pipeline stage.
    always_comb
    begin
        if (key_q[7:0] == IPP_TCP)
        begin
            case (cst_q)
                CS_ESTABLISHED: timeout_c = to_est_reg;
                CS_FIN_WAIT:    timeout_c = to_close_reg;
                CS_CLOSE_WAIT:  timeout_c = to_close_reg;
                default:        timeout_c = to_hs_reg;
            endcase
        end
        else if (key_q[7:0] == IPP_ICMP)
            timeout_c = to_icmp_reg;
        else
            timeout_c = to_udp_reg;
    end
    assign idle_c   = now_reg - last_q;
    assign expire_c = p_valid_slot && (idle_c > 32'(timeout_c));

    // Rank write port: rank rewrite walk and gap closing walk.
    always_comb
    begin
        rk_we   = 1'b0;
        rk_addr = p_idx_reg;
        rk_data = rank_q;
        if (state_reg == S_RANK && p_vld_reg && p_valid_slot)
        begin
            case (mode_reg)
                M_PROMOTE:
                begin
                    if (p_idx_reg == ms_reg)
                    begin
                        rk_we   = 1'b1;
                        rk_data = '0;
                    end
                    else if (rank_q < mr_reg)
                    begin
                        rk_we   = 1'b1;
                        rk_data = rank_q + 1'b1;
                    end
                end
                M_INSERT:
                begin
                    rk_we = 1'b1;
                    if (p_idx_reg == ms_reg)
                        rk_data = '0;
                    else if (mev_reg && rank_q > mr_reg)
                        rk_data = rank_q;
                    else
                        rk_data = rank_q + 1'b1;
                end
                M_DROP:
                begin
                    if (rank_q > mr_reg)
                    begin
                        rk_we   = 1'b1;
                        rk_data = rank_q - 1'b1;
                    end
                end
                default:
                begin
                    rk_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_COMP && p2_vld_reg && valid_reg[p2_idx_reg])
        begin
            rk_we   = 1'b1;
            rk_addr = p2_idx_reg;
            rk_data = p2_rank_reg - shift_q;
        end
    end

    // Entry field writes happen on insert, hit refresh and touch.
    always_comb
    begin
        ent_we    = (state_reg == S_DECIDE) && (act_reg == ACT_LOOKUP) && !fnd_reg && ins_c;
        last_we   = ((state_reg == S_DECIDE) && (act_reg == ACT_LOOKUP) && (fnd_reg || ins_c))
                    || (state_reg == S_TWAIT);
        cst_we    = ent_we || (state_reg == S_TWAIT);
        last_addr = (state_reg == S_TWAIT) ? sidx_w : (fnd_reg ? f_slot_reg : ns_c);
        cst_addr  = (state_reg == S_TWAIT) ? sidx_w : ns_c;
        cst_data  = (state_reg == S_TWAIT) ? nst_reg : CS_CLOSED;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        key_q   <= key_mem[rd_addr];
        last_q  <= last_mem[rd_addr];
        first_q <= first_mem[rd_addr];
        cst_q   <= cst_mem[rd_addr];
        rank_q  <= rank_mem[rd_addr];
        shift_q <= shift_mem[rank_q];
        if (ent_we)
        begin
            key_mem[ns_c]   <= key_reg;
            first_mem[ns_c] <= now_reg;
        end
        if (last_we)
            last_mem[last_addr] <= now_reg;
        if (cst_we)
            cst_mem[cst_addr] <= cst_data;
        if (rk_we)
            rank_mem[rk_addr] <= rk_data;
        if (state_reg == S_SHIFT && iss_reg)
            shift_mem[idx_reg] <= run_reg;
    end

    // Payload captures that need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            key_reg  <= {src_addr, dst_addr, src_port, dst_port, protocol};
            now_reg  <= now;
            sidx_reg <= slot_index;
            nst_reg  <= new_conn_state;
        end
        p_idx_reg   <= idx_reg;
        p2_idx_reg  <= p_idx_reg;
        p2_rank_reg <= rank_q;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= 7'd64;
            to_hs_reg    <= 16'd30;
            to_est_reg   <= 16'd3600;
            to_close_reg <= 16'd60;
            to_udp_reg   <= 16'd30;
            to_icmp_reg  <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY:  cap_reg      <= cfg_data[6:0];
                REG_TCP_HS:    to_hs_reg    <= cfg_data;
                REG_TCP_EST:   to_est_reg   <= cfg_data;
                REG_TCP_CLOSE: to_close_reg <= cfg_data;
                REG_UDP:       to_udp_reg   <= cfg_data;
                REG_ICMP:      to_icmp_reg  <= cfg_data;
                default:       cap_reg      <= cap_reg;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            iss_reg       <= 1'b0;
            p_vld_reg     <= 1'b0;
            p2_vld_reg    <= 1'b0;
            fnd_reg       <= 1'b0;
            vic_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            f_slot_reg    <= '0;
            f_rank_reg    <= '0;
            f_first_reg   <= '0;
            f_st_reg      <= '0;
            vic_reg       <= '0;
            best_reg      <= '0;
            free_reg      <= '0;
            mode_reg      <= M_PROMOTE;
            ms_reg        <= '0;
            mr_reg        <= '0;
            mev_reg       <= 1'b0;
            valid_reg     <= '0;
            drop_mask_reg <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            run_reg       <= '0;
            r_hit_reg     <= 1'b0;
            r_err_reg     <= 1'b0;
            r_ev_reg      <= 1'b0;
            r_slot_reg    <= '0;
            r_first_reg   <= '0;
            r_st_reg      <= '0;
            out_valid_reg <= 1'b0;
            ov_hit_reg    <= 1'b0;
            ov_err_reg    <= 1'b0;
            ov_ev_reg     <= 1'b0;
            ov_slot_reg   <= '0;
            ov_rem_reg    <= '0;
            ov_occ_reg    <= '0;
            ov_first_reg  <= '0;
            ov_st_reg     <= '0;
        end
        else
        begin
            p_vld_reg  <= iss_reg;
            p2_vld_reg <= p_vld_reg;
            if (iss_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    iss_reg <= 1'b0;
            end
            // In S_DONE the output register is reloaded instead.
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        r_hit_reg    <= 1'b0;
                        r_err_reg    <= 1'b0;
                        r_ev_reg     <= 1'b0;
                        r_slot_reg   <= '0;
                        r_first_reg  <= '0;
                        r_st_reg     <= '0;
                        rem_reg      <= '0;
                        fnd_reg      <= 1'b0;
                        vic_vld_reg  <= 1'b0;
                        free_vld_reg <= 1'b0;
                        case (action)
                            ACT_TOUCH:
                            begin
                                state_reg <= S_TREAD;
                            end
                            ACT_SWEEP:
                            begin
                                drop_mask_reg <= '0;
                                idx_reg       <= '0;
                                iss_reg       <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                            default:
                            begin
                                idx_reg   <= '0;
                                iss_reg   <= 1'b1;
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (p_vld_reg)
                    begin
                        if (p_valid_slot)
                        begin
                            if (!fnd_reg && key_q == key_reg)
                            begin
                                fnd_reg     <= 1'b1;
                                f_slot_reg  <= p_idx_reg;
                                f_rank_reg  <= rank_q;
                                f_first_reg <= first_q;
                                f_st_reg    <= cst_q;
                            end
                            // Ties go to the highest slot.
                            if (!vic_vld_reg || rank_q >= best_reg)
                            begin
                                vic_vld_reg <= 1'b1;
                                vic_reg     <= p_idx_reg;
                                best_reg    <= rank_q;
                            end
                        end
                        else if (!free_vld_reg)
                        begin
                            free_vld_reg <= 1'b1;
                            free_reg     <= p_idx_reg;
                        end
                    end
                    if (pass_done)
                        state_reg <= S_DECIDE;
                end

                S_DECIDE:
                begin
                    idx_reg <= '0;
                    if (act_reg == ACT_LOOKUP)
                    begin
                        if (fnd_reg)
                        begin
                            r_hit_reg   <= 1'b1;
                            r_slot_reg  <= 6'(f_slot_reg);
                            r_first_reg <= f_first_reg;
                            r_st_reg    <= f_st_reg;
                            mode_reg    <= M_PROMOTE;
                            ms_reg      <= f_slot_reg;
                            mr_reg      <= f_rank_reg;
                            iss_reg     <= 1'b1;
                            state_reg   <= S_RANK;
                        end
                        else if (ins_c)
                        begin
                            r_ev_reg    <= evict_c;
                            r_slot_reg  <= 6'(ns_c);
                            r_first_reg <= now_reg;
                            r_st_reg    <= CS_CLOSED;
                            // The victim slot may be the one that is refilled.
                            if (evict_c)
                                valid_reg <= (valid_reg & ~(TABLE_SLOTS'(1) << vic_reg))
                                             | (TABLE_SLOTS'(1) << ns_c);
                            else
                                valid_reg[ns_c] <= 1'b1;
                            count_reg   <= evict_c ? count_reg : count_reg + 1'b1;
                            mode_reg    <= M_INSERT;
                            ms_reg      <= ns_c;
                            mr_reg      <= best_reg;
                            mev_reg     <= evict_c;
                            iss_reg     <= 1'b1;
                            state_reg   <= S_RANK;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (fnd_reg)
                        begin
                            r_hit_reg   <= 1'b1;
                            r_slot_reg  <= 6'(f_slot_reg);
                            r_first_reg <= f_first_reg;
                            r_st_reg    <= f_st_reg;
                            valid_reg[f_slot_reg] <= 1'b0;
                            count_reg   <= count_reg - 1'b1;
                            mode_reg    <= M_DROP;
                            mr_reg      <= f_rank_reg;
                            iss_reg     <= 1'b1;
                            state_reg   <= S_RANK;
                        end
                        else
                        begin
                            r_err_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_TREAD:
                begin
                    r_slot_reg <= sidx_reg;
                    if (!sidx_ok || !valid_reg[sidx_w])
                    begin
                        r_err_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_TWAIT;
                end

                S_TWAIT:
                begin
                    r_first_reg <= first_q;
                    r_st_reg    <= nst_reg;
                    mode_reg    <= M_PROMOTE;
                    ms_reg      <= sidx_w;
                    mr_reg      <= rank_q;
                    idx_reg     <= '0;
                    iss_reg     <= 1'b1;
                    state_reg   <= S_RANK;
                end

                S_RANK:
                begin
                    if (pass_done)
                        state_reg <= S_DONE;
                end

                S_SWEEP:
                begin
                    if (p_vld_reg && expire_c)
                    begin
                        valid_reg[p_idx_reg] <= 1'b0;
                        drop_mask_reg[rank_q] <= 1'b1;
                        rem_reg <= rem_reg + 1'b1;
                    end
                    if (pass_done)
                    begin
                        count_reg <= count_reg - rem_reg;
                        run_reg   <= '0;
                        idx_reg   <= '0;
                        iss_reg   <= 1'b1;
                        state_reg <= S_SHIFT;
                    end
                end

                S_SHIFT:
                begin
                    if (iss_reg && drop_mask_reg[idx_reg])
                        run_reg <= run_reg + 1'b1;
                    if (pass_done)
                    begin
                        idx_reg   <= '0;
                        iss_reg   <= 1'b1;
                        state_reg <= S_COMP;
                    end
                end

                S_COMP:
                begin
                    if (pass_done)
                        state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        ov_hit_reg    <= r_hit_reg;
                        ov_err_reg    <= r_err_reg;
                        ov_ev_reg     <= r_ev_reg;
                        ov_slot_reg   <= r_slot_reg;
                        ov_rem_reg    <= 7'(rem_reg);
                        ov_occ_reg    <= 7'(count_reg);
                        ov_first_reg  <= r_first_reg;
                        ov_st_reg     <= r_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit              = ov_hit_reg;
    assign slot             = ov_slot_reg;
    assign error            = ov_err_reg;
    assign evicted          = ov_ev_reg;
    assign removed_count    = ov_rem_reg;
    assign occupancy        = ov_occ_reg;
    assign entry_first_seen = ov_first_reg;
    assign entry_state      = ov_st_reg;

endmodule

`default_nettype wire
